FILE: rtl/core/ptab_pkg.sv
// ----------------------------------------------------------------------------
// Process table package
// Shared types, constants and codes for the priority-ordered process table.
// ----------------------------------------------------------------------------
package ptab_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Root entry and first free id.
	localparam logic [15:0] ROOT_PID  = 16'd1024;
	localparam logic [15:0] FIRST_PID = 16'd1025;

	// Operation codes.
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_PRIO_REJ = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOT_FND  = 2'd3;

	// Input item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  priority_req;
		logic [15:0] target_pid;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result_pid;
		logic [7:0]  entry_priority;
		logic [15:0] parent_pid;
		logic        entry_state;
	} rsp_item_t;

	// One slot of the table.
	typedef struct packed {
		logic [15:0] pid;
		logic [7:0]  prio;
		logic [15:0] parent;
		logic        runnable;
	} entry_t;

	localparam entry_t ROOT_ENTRY = '{pid: ROOT_PID, prio: 8'd0, parent: ROOT_PID,
		runnable: 1'b1};

	// Request from the sequencer to the slot memory.
	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	// Failure result: all fields but the status are zero.
	function automatic rsp_item_t fail_item(logic [1:0] st);
		rsp_item_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

endpackage

FILE: rtl/core/ptab_mem.sv
// ----------------------------------------------------------------------------
// Process table slot memory
// One write port and one registered read port; slot 0 always reads as root.
// ----------------------------------------------------------------------------
module ptab_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  ptab_pkg::mem_req_t req,
	output ptab_pkg::entry_t   rd_data
);
	import ptab_pkg::*;

	entry_t mem_q [TABLE_DEPTH];
	entry_t rd_data_q;
	logic   rd_root_q;

	// Write port and registered read of the array.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem_q[req.rd_addr];
	end

	// Slot 0 is never written, so the root entry is supplied by logic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_root_q <= 1'b0;
		end else begin
			rd_root_q <= (req.rd_addr == '0);
		end
	end

	assign rd_data = rd_root_q ? ROOT_ENTRY : rd_data_q;

endmodule

FILE: rtl/core/ptab_ctrl.sv
// ----------------------------------------------------------------------------
// Process table sequencer
// Walks the slot memory one slot per cycle through a shared compare unit to
// search, insert and remove entries, and forms the result item.
// ----------------------------------------------------------------------------
module ptab_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ptab_pkg::req_item_t req,
	output logic                fin_valid,
	input  logic                fin_ready,
	output ptab_pkg::rsp_item_t fin,
	output ptab_pkg::mem_req_t  mreq,
	input  ptab_pkg::entry_t    rd_data
);
	import ptab_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT_UP,
		ST_PUT,
		ST_SHIFT_DN,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [1:0]       op_q;
	logic [7:0]       prio_q;
	logic [15:0]      target_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      next_pid_q;
	logic [CNT_W-1:0] idx_q;
	logic             ret_v_q;
	logic [IDX_W-1:0] ret_idx_q;
	logic [CNT_W-1:0] pos_q;
	logic             pos_hit_q;
	logic             par_hit_q;
	rsp_item_t        fin_q;

	logic [CNT_W-1:0] idx_dec;
	logic             id_eq;
	logic             pr_gt;
	entry_t           new_entry;

	assign idx_dec = idx_q - CNT_W'(1);

	// Shared compare unit on the slot just read.
	assign id_eq = (rd_data.pid == target_q);
	assign pr_gt = (rd_data.prio > prio_q);

	assign new_entry = '{pid: next_pid_q, prio: prio_q,
		parent: (par_hit_q ? target_q : 16'd0), runnable: 1'b0};

	// Memory addressing for each phase.
	always_comb begin
		mreq         = '0;
		mreq.rd_addr = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_SHIFT_UP: begin
				mreq.rd_addr = idx_dec[IDX_W-1:0];
				mreq.wr_en   = ret_v_q;
				mreq.wr_addr = ret_idx_q;
				mreq.wr_data = rd_data;
			end
			ST_SHIFT_DN: begin
				mreq.wr_en   = ret_v_q;
				mreq.wr_addr = ret_idx_q;
				mreq.wr_data = rd_data;
			end
			ST_PUT: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = pos_q[IDX_W-1:0];
				mreq.wr_data = new_entry;
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);
	assign fin_valid = (state_q == ST_FIN);
	assign fin       = fin_q;

	// Sequencer state and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= CNT_W'(1);
			next_pid_q <= FIRST_PID;
			ret_v_q    <= 1'b0;
			idx_q      <= '0;
			pos_hit_q  <= 1'b0;
			par_hit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ret_v_q   <= 1'b0;
					pos_hit_q <= 1'b0;
					par_hit_q <= 1'b0;
					if (req_valid) begin
						op_q     <= req.kind;
						prio_q   <= req.priority_req;
						target_q <= req.target_pid;
						if (req.kind == OP_CREATE && req.priority_req == 8'd0) begin
							fin_q   <= fail_item(STAT_PRIO_REJ);
							state_q <= ST_FIN;
						end else if (req.kind == OP_CREATE &&
								count_q == CNT_W'(TABLE_DEPTH)) begin
							fin_q   <= fail_item(STAT_FULL);
							state_q <= ST_FIN;
						end else if (req.kind == OP_CREATE || req.kind == OP_LOOKUP) begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end else if (req.kind == OP_REMOVE) begin
							idx_q   <= CNT_W'(1);
							state_q <= ST_SCAN;
						end else begin
							fin_q   <= fail_item(STAT_NOT_FND);
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					// Issue the next slot read while data of the last one returns,
					// unless the entry to remove has just been found.
					if (ret_v_q && id_eq && op_q == OP_REMOVE) begin
						pos_q   <= CNT_W'(ret_idx_q);
						idx_q   <= CNT_W'(ret_idx_q) + CNT_W'(1);
						ret_v_q <= 1'b0;
						state_q <= ST_SHIFT_DN;
					end else if (idx_q < count_q) begin
						idx_q     <= idx_q + CNT_W'(1);
						ret_v_q   <= 1'b1;
						ret_idx_q <= idx_q[IDX_W-1:0];
					end else begin
						ret_v_q <= 1'b0;
					end
					if (ret_v_q) begin
						if (op_q == OP_CREATE) begin
							if (id_eq) begin
								par_hit_q <= 1'b1;
							end
							if (pr_gt && !pos_hit_q) begin
								pos_hit_q <= 1'b1;
								pos_q     <= CNT_W'(ret_idx_q);
							end
						end else if (id_eq) begin
							fin_q <= '{status: STAT_OK, result_pid: rd_data.pid,
								entry_priority: rd_data.prio, parent_pid: rd_data.parent,
								entry_state: rd_data.runnable};
							if (op_q == OP_LOOKUP) begin
								state_q <= ST_FIN;
							end
						end
					end else if (idx_q == count_q) begin
						// Every slot has been compared.
						if (op_q == OP_CREATE) begin
							if (!pos_hit_q) begin
								pos_q <= count_q;
							end
							state_q <= ST_SHIFT_UP;
						end else begin
							fin_q   <= fail_item(STAT_NOT_FND);
							state_q <= ST_FIN;
						end
					end
				end
				ST_SHIFT_UP: begin
					// Move slots from the top down to the insertion point up by one.
					if (idx_q > pos_q) begin
						idx_q     <= idx_dec;
						ret_v_q   <= 1'b1;
						ret_idx_q <= idx_q[IDX_W-1:0];
					end else begin
						ret_v_q <= 1'b0;
					end
					if (!ret_v_q && idx_q == pos_q) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					count_q    <= count_q + CNT_W'(1);
					next_pid_q <= next_pid_q + 16'd1;
					fin_q      <= '{status: STAT_OK, result_pid: next_pid_q,
						entry_priority: prio_q, parent_pid: new_entry.parent,
						entry_state: 1'b0};
					state_q    <= ST_FIN;
				end
				ST_SHIFT_DN: begin
					// Move slots above the removed one down by one.
					if (idx_q < count_q) begin
						idx_q     <= idx_q + CNT_W'(1);
						ret_v_q   <= 1'b1;
						ret_idx_q <= idx_dec[IDX_W-1:0];
					end else begin
						ret_v_q <= 1'b0;
					end
					if (!ret_v_q && idx_q == count_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The root always stays and the table never overflows.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(1) && count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count out of range");

	// The root slot is never overwritten.
	a_root_kept: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.wr_en |-> mreq.wr_addr != '0)
		else $error("write to root slot");

	// A failed operation reports all other fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid && fin.status != STAT_OK) |->
		(fin.result_pid == 16'd0 && fin.entry_priority == 8'd0 &&
		fin.parent_pid == 16'd0 && !fin.entry_state))
		else $error("failure result carries data");

	// The count moves only on completing an insert or a removal.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_PUT && state_q != ST_SHIFT_DN) |=> $stable(count_q))
		else $error("entry count changed unexpectedly");

endmodule

FILE: rtl/core/priority_ordered_process_table_top.sv
// ----------------------------------------------------------------------------
// Priority-ordered process table
// Keeps process entries sorted by priority behind a valid/ready item port.
// ----------------------------------------------------------------------------
// A rejected or undefined item goes straight to the result; a lookup scans until
// it hits or the table ends; a remove scans for its entry and shifts the slots
// above it down; a create scans every slot, shifts the slots above its place up
// and writes the new entry. One slot is read per cycle through the single read
// port; the sequencer is back in idle, ready for the next item, once a result is registered.
// Reset: control state clears at once; the root entry is held in logic, so no
// clearing pass is needed and the first item is taken right after reset.
module priority_ordered_process_table_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ptab_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ptab_pkg::rsp_item_t rsp
);
	import ptab_pkg::*;

	mem_req_t  mreq;
	entry_t    rd_data;
	logic      fin_valid;
	logic      fin_ready;
	rsp_item_t fin;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	ptab_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd_data)
	);

	ptab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin),
		.mreq      (mreq),
		.rd_data   (rd_data)
	);

	// Output register: holds a finished item until it is taken.
	assign fin_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_ready) begin
			rsp_valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			rsp_q <= fin;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: dv/priority_ordered_process_table_top_test.sv
// ----------------------------------------------------------------------------
// Process table testbench
// Drives create, remove, lookup and undefined items into the priority-ordered process
// table under random idling on both sides. A shadow copy of the table predicts
// every reply, and each reply is checked field by field in arrival order. The
// table is drained down to the root once between the two random stretches.
// ----------------------------------------------------------------------------
module priority_ordered_process_table_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ptab_pkg::*;

	// The one operation code that the package leaves unnamed.
	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	// Cycles with no accepted item before the run is abandoned.
	localparam int QUIET_LIMIT = 3000;
	// Cycles to wait after the last reply for anything stray.
	localparam int SETTLE_CYCLES = 100;

	// Shadow table: predicts replies and holds those still to arrive.
	class process_table_shadow;
		entry_t      slots[TABLE_DEPTH];
		int          count;
		logic [15:0] next_id;
		rsp_item_t   pending_replies[$];
		int          errors;
		int          replies_checked;
		int          status_seen[4];

		function new();
			foreach (slots[i])
				slots[i] = '0;
			slots[0] = ROOT_ENTRY;
			count = 1;
			next_id = FIRST_PID;
			errors = 0;
			replies_checked = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		// First slot at or after start holding the id, or -1.
		function int locate(int start, logic [15:0] id);
			for (int i = start; i < count; i++)
				if (slots[i].pid == id)
					return i;
			return -1;
		endfunction

		// Applies one item to the shadow table and returns the reply it causes.
		function rsp_item_t apply_request(req_item_t item);
			rsp_item_t res;
			int        hit;
			int        pos;
			res = '0;
			case (item.kind)
				OP_CREATE: begin
					if (item.priority_req == 8'd0) begin
						res.status = STAT_PRIO_REJ;
					end else if (count == TABLE_DEPTH) begin
						res.status = STAT_FULL;
					end else begin
						res.status = STAT_OK;
						res.result_pid = next_id;
						res.entry_priority = item.priority_req;
						res.parent_pid = (locate(0, item.target_pid) >= 0) ?
							item.target_pid : 16'd0;
						res.entry_state = 1'b0;
						next_id = next_id + 16'd1;
						// The new entry goes after every entry of equal or lower priority.
						pos = count;
						for (int i = 0; i < count; i++) begin
							if (slots[i].prio > item.priority_req) begin
								pos = i;
								break;
							end
						end
						for (int i = count; i > pos; i--)
							slots[i] = slots[i - 1];
						slots[pos].pid = res.result_pid;
						slots[pos].prio = res.entry_priority;
						slots[pos].parent = res.parent_pid;
						slots[pos].runnable = 1'b0;
						count++;
					end
				end
				OP_REMOVE: begin
					// The root in slot 0 is never a candidate.
					hit = locate(1, item.target_pid);
					if (hit < 0) begin
						res.status = STAT_NOT_FND;
					end else begin
						res.status = STAT_OK;
						res.result_pid = slots[hit].pid;
						res.entry_priority = slots[hit].prio;
						res.parent_pid = slots[hit].parent;
						res.entry_state = slots[hit].runnable;
						for (int i = hit; i + 1 < count; i++)
							slots[i] = slots[i + 1];
						count--;
						slots[count] = '0;
					end
				end
				OP_LOOKUP: begin
					hit = locate(0, item.target_pid);
					if (hit < 0) begin
						res.status = STAT_NOT_FND;
					end else begin
						res.status = STAT_OK;
						res.result_pid = slots[hit].pid;
						res.entry_priority = slots[hit].prio;
						res.parent_pid = slots[hit].parent;
						res.entry_state = slots[hit].runnable;
					end
				end
				default: begin
					res.status = STAT_NOT_FND;
				end
			endcase
			status_seen[res.status]++;
			return res;
		endfunction

		// Notes an accepted item and queues the reply it should produce.
		function void note_request(req_item_t item);
			pending_replies.push_back(apply_request(item));
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 10)
					$display("Reply %0d: %s expected %0d, got %0d", replies_checked,
						field, want, got);
			end
		endfunction

		// Checks one accepted reply against the oldest prediction.
		function void check_reply(rsp_item_t got);
			rsp_item_t want;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Reply with nothing outstanding: status %0d, pid %0d",
						got.status, got.result_pid);
				return;
			end
			want = pending_replies.pop_front();
			replies_checked++;
			compare_field("status", want.status, got.status);
			compare_field("result_pid", want.result_pid, got.result_pid);
			compare_field("entry_priority", want.entry_priority, got.entry_priority);
			compare_field("parent_pid", want.parent_pid, got.parent_pid);
			compare_field("entry_state", want.entry_state, got.entry_state);
		endfunction

		// Random id of an entry in the table; the root is skipped when asked, unless nothing else is there.
		function logic [15:0] pick_live_id(bit skip_root);
			if (count == 1)
				return ROOT_PID;
			return slots[$urandom_range(count - 1, skip_root ? 1 : 0)].pid;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_item_t           req;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_item_t           rsp;

	process_table_shadow shadow;
	bit                  sender_idles;
	bit                  receiver_idles;
	int                  quiet_cycles;

	priority_ordered_process_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Reply side: ready changes at the falling edge, with random stalls.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ready = !(receiver_idles && $urandom_range(99) < 16);
		end
	end

	// Every accepted reply is checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			shadow.check_reply(rsp);
	end

	// Watchdog: too long without any accepted item on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item accepted for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic req_item_t make_request(logic [1:0] kind, logic [7:0] prio,
		logic [15:0] pid);
		req_item_t item;
		item.kind = kind;
		item.priority_req = prio;
		item.target_pid = pid;
		return item;
	endfunction

	// Presents one item and returns at the falling edge after its acceptance.
	// Called at a falling edge; valid stays high between back-to-back items.
	task automatic send_request(input req_item_t item);
		while (sender_idles && $urandom_range(99) < 16) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = item;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		shadow.note_request(item);
		@(negedge clk);
	endtask

	// Holds the sender back until every predicted reply has arrived.
	task automatic wait_replies();
		req_valid = 1'b0;
		while (shadow.pending_replies.size() != 0)
			@(negedge clk);
	endtask

	// One random item, mostly well formed, weighted by the current mix.
	function automatic req_item_t random_request(int mix);
		int          roll;
		int          p_create;
		int          p_remove;
		logic [7:0]  prio;
		logic [15:0] pid;
		case (mix)
			0: begin
				p_create = 65;
				p_remove = 15;
			end
			1: begin
				p_create = 20;
				p_remove = 55;
			end
			default: begin
				p_create = 40;
				p_remove = 35;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < 3)
			return make_request(OP_UNDEFINED, 8'($urandom_range(255)),
				16'($urandom_range(16'hFFFF)));
		if (roll < 3 + p_create) begin
			// Narrow priorities give plenty of ties; zero is the rejected case.
			roll = $urandom_range(99);
			if (roll < 5)
				prio = 8'd0;
			else if (roll < 10)
				prio = 8'd1;
			else if (roll < 15)
				prio = 8'd255;
			else if (roll < 40)
				prio = 8'($urandom_range(4, 1));
			else
				prio = 8'($urandom_range(255, 1));
			pid = ($urandom_range(99) < 70) ? shadow.pick_live_id(1'b0) :
				16'($urandom_range(16'hFFFF));
			return make_request(OP_CREATE, prio, pid);
		end
		if (roll < 3 + p_create + p_remove) begin
			roll = $urandom_range(99);
			if (roll < 80)
				pid = shadow.pick_live_id(1'b1);
			else if (roll < 90)
				pid = ROOT_PID;
			else
				pid = 16'($urandom_range(16'hFFFF));
			return make_request(OP_REMOVE, 8'($urandom_range(255)), pid);
		end
		pid = ($urandom_range(99) < 80) ? shadow.pick_live_id(1'b0) :
			16'($urandom_range(16'hFFFF));
		return make_request(OP_LOOKUP, 8'($urandom_range(255)), pid);
	endfunction

	// Random items; the mix is redrawn every 60 items so the table fills and drains.
	task automatic random_phase(input int n_items, input int calm_from, input int calm_to,
		input int pause_at);
		int mix;
		mix = 2;
		for (int n = 0; n < n_items; n++) begin
			if (n % 60 == 0)
				mix = $urandom_range(2);
			sender_idles = !(n >= calm_from && n < calm_to);
			receiver_idles = sender_idles;
			if (n == pause_at)
				wait_replies();
			send_request(random_request(mix));
		end
	endtask

	initial begin
		shadow = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		quiet_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed items: root handling, rejections, ordering and misses.
		send_request(make_request(OP_LOOKUP, 8'd0, ROOT_PID));
		send_request(make_request(OP_LOOKUP, 8'hFF, 16'd0));
		send_request(make_request(OP_REMOVE, 8'd0, ROOT_PID));
		send_request(make_request(OP_REMOVE, 8'd0, 16'hFFFF));
		send_request(make_request(OP_CREATE, 8'd0, ROOT_PID));
		send_request(make_request(OP_CREATE, 8'd255, ROOT_PID));
		send_request(make_request(OP_CREATE, 8'd1, 16'hFFFF));
		send_request(make_request(OP_CREATE, 8'd255, 16'd1025));
		send_request(make_request(OP_CREATE, 8'd1, 16'd1026));
		send_request(make_request(OP_LOOKUP, 8'd0, 16'd1027));
		send_request(make_request(OP_UNDEFINED, 8'hFF, 16'hFFFF));
		send_request(make_request(OP_UNDEFINED, 8'h00, 16'h0000));
		send_request(make_request(OP_REMOVE, 8'd0, 16'd1027));
		send_request(make_request(OP_LOOKUP, 8'd0, 16'd1027));
		send_request(make_request(OP_REMOVE, 8'd0, 16'd1026));
		send_request(make_request(OP_CREATE, 8'd128, 16'd0));
		send_request(make_request(OP_LOOKUP, 8'd0, 16'hFFFF));
		send_request(make_request(OP_LOOKUP, 8'd0, 16'd1025));

		// First random stretch, with a quiet run and one full drain inside it.
		random_phase(420, 150, 300, 300);

		// Empty the table down to the root, removing the last entry each time.
		wait_replies();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		while (shadow.count > 1)
			send_request(make_request(OP_REMOVE, 8'd0,
				shadow.slots[shadow.count - 1].pid));
		send_request(make_request(OP_LOOKUP, 8'd0, ROOT_PID));
		send_request(make_request(OP_REMOVE, 8'd0, ROOT_PID));

		// Second random stretch, refilling the table from the root alone.
		random_phase(400, 100, 180, -1);

		// Drain, then give a stray reply time to show up.
		wait_replies();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (shadow.pending_replies.size() != 0) begin
			$display("%0d predicted replies never arrived", shadow.pending_replies.size());
			shadow.errors += shadow.pending_replies.size();
		end

		$display("Checked %0d replies: %0d ok, %0d zero priority, %0d table full, %0d missing.",
			shadow.replies_checked, shadow.status_seen[STAT_OK],
			shadow.status_seen[STAT_PRIO_REJ], shadow.status_seen[STAT_FULL],
			shadow.status_seen[STAT_NOT_FND]);
		$display("Table filled, drained to the root and refilled; %0d field errors.",
			shadow.errors);
		if (shadow.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
